// ===== hdl/fbac_pkg.sv =====
// shared types and constants for the four-bit accumulator cpu
// word structs, opcode codes and the memory write request used by all modules
`default_nettype none

package fbac_pkg;

  // memory size and field widths
  localparam int unsigned MEM_WORDS = 16;
  localparam int unsigned ADDR_W    = 4;
  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned NIB_W     = 4;

  // action codes of an input word
  localparam logic ACT_LOAD = 1'b0;
  localparam logic ACT_STEP = 1'b1;

  // opcodes in the high nibble of an instruction
  typedef enum logic [NIB_W-1:0] {
    OP_NOP = 4'd0,
    OP_LDA = 4'd1,
    OP_ADD = 4'd2,
    OP_SUB = 4'd3,
    OP_STO = 4'd4,
    OP_OUT = 4'd5,
    OP_JMP = 4'd6,
    OP_HLT = 4'd7,
    OP_CMP = 4'd8
  } opcode_e;

  // input word
  typedef struct packed {
    logic              action;
    logic [ADDR_W-1:0] load_address;
    logic [BYTE_W-1:0] load_data;
  } fbac_in_t;

  // result word
  typedef struct packed {
    logic              out_valid;
    logic [BYTE_W-1:0] out_value;
    logic              halted;
    logic [ADDR_W-1:0] program_counter;
    logic [BYTE_W-1:0] fetched_instruction;
  } fbac_out_t;

  // memory write request from the execute unit
  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    logic [BYTE_W-1:0] data;
  } fbac_wr_t;

endpackage

`default_nettype wire

// ===== hdl/fbac_regfile.sv =====
// program and data memory of the accumulator cpu, held in flip-flops
// two combinational read ports, one write port; uses fbac_pkg
`default_nettype none

module fbac_regfile #(
  parameter int unsigned MemWords = fbac_pkg::MEM_WORDS
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire fbac_pkg::fbac_wr_t             wr_i,
  input  wire logic [fbac_pkg::ADDR_W-1:0]    raddr_a_i,
  input  wire logic [fbac_pkg::ADDR_W-1:0]    raddr_b_i,
  output logic      [fbac_pkg::BYTE_W-1:0]    rdata_a_o,
  output logic      [fbac_pkg::BYTE_W-1:0]    rdata_b_o
);
  import fbac_pkg::*;

  localparam int unsigned AW = $clog2(MemWords);

  logic [BYTE_W-1:0] mem_q [MemWords];

  // byte storage, cleared by reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < MemWords; i++) begin
        mem_q[i] <= '0;
      end
    end else if (wr_i.en) begin
      mem_q[wr_i.addr[AW-1:0]] <= wr_i.data;
    end
  end

  // fetch and operand read ports
  assign rdata_a_o = mem_q[raddr_a_i[AW-1:0]];
  assign rdata_b_o = mem_q[raddr_b_i[AW-1:0]];

endmodule

`default_nettype wire

// ===== hdl/fbac_exec.sv =====
// execute unit: accumulator, program counter, instruction register and halt flag
// fetches, decodes and executes one word per strobe; uses fbac_pkg
`default_nettype none

module fbac_exec (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         go_i,
  input  wire fbac_pkg::fbac_in_t           word_i,
  output logic      [fbac_pkg::ADDR_W-1:0]  raddr_a_o,
  output logic      [fbac_pkg::ADDR_W-1:0]  raddr_b_o,
  input  wire logic [fbac_pkg::BYTE_W-1:0]  rdata_a_i,
  input  wire logic [fbac_pkg::BYTE_W-1:0]  rdata_b_i,
  output fbac_pkg::fbac_wr_t                wr_o,
  output fbac_pkg::fbac_out_t               res_o
);
  import fbac_pkg::*;

  logic [BYTE_W-1:0] acc_q, acc_d;
  logic [ADDR_W-1:0] pc_q, pc_d;
  logic [BYTE_W-1:0] ir_q, ir_d;
  logic              halt_q, halt_d;
  logic              shown;
  logic [ADDR_W-1:0] pc_inc;
  logic [NIB_W-1:0]  arg;

  // fetch at pc, operand at the low nibble of the fetched byte
  assign raddr_a_o = pc_q;
  assign arg       = rdata_a_i[NIB_W-1:0];
  assign raddr_b_o = arg;
  assign pc_inc    = pc_q + ADDR_W'(1);

  // decode and execute
  always_comb begin
    acc_d   = acc_q;
    pc_d    = pc_q;
    ir_d    = ir_q;
    halt_d  = halt_q;
    shown   = 1'b0;
    wr_o.en   = 1'b0;
    wr_o.addr = word_i.load_address;
    wr_o.data = word_i.load_data;
    if (go_i) begin
      if (word_i.action == ACT_LOAD) begin
        wr_o.en = 1'b1;
      end else if (!halt_q) begin
        ir_d = rdata_a_i;
        pc_d = pc_inc;
        unique case (opcode_e'(rdata_a_i[BYTE_W-1:NIB_W]))
          OP_LDA: acc_d = rdata_b_i;
          OP_ADD: acc_d = {{(BYTE_W-NIB_W){1'b0}}, acc_q[NIB_W-1:0] + rdata_b_i[NIB_W-1:0]};
          OP_SUB: acc_d = {{(BYTE_W-NIB_W){1'b0}}, acc_q[NIB_W-1:0] - rdata_b_i[NIB_W-1:0]};
          OP_STO: begin
            wr_o.en   = 1'b1;
            wr_o.addr = arg;
            wr_o.data = acc_q;
          end
          OP_OUT: shown = 1'b1;
          OP_JMP: pc_d = arg;
          OP_HLT: begin
            halt_d = 1'b1;
            pc_d   = pc_q;
          end
          OP_CMP: begin
            if (acc_q == rdata_b_i) begin
              pc_d = pc_q + ADDR_W'(2);
            end
          end
          default: ;
        endcase
      end
    end
  end

  // architectural state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q  <= '0;
      pc_q   <= '0;
      ir_q   <= '0;
      halt_q <= 1'b0;
    end else if (go_i) begin
      acc_q  <= acc_d;
      pc_q   <= pc_d;
      ir_q   <= ir_d;
      halt_q <= halt_d;
    end
  end

  // result word reports the state after this item
  assign res_o.out_valid           = shown;
  assign res_o.out_value           = acc_d;
  assign res_o.halted              = halt_d;
  assign res_o.program_counter     = pc_d;
  assign res_o.fetched_instruction = ir_d;

endmodule

`default_nettype wire

// ===== hdl/four_bit_accumulator_cpu.sv =====
// Four-bit accumulator cpu with a 16-byte memory. A load word (action 0) writes
// one memory byte; a step word (action 1) fetches the byte at the program counter
// and executes it, unless the machine is halted. Every input word gives exactly
// one result word carrying the state after it. One word is taken per clock cycle
// while the input is not stalled: the input register feeds fetch, decode and
// execute over a flip-flop register file, which loads the result register.
// The input stalls only while a word is held and the result register is full
// and stalled. The memory is cleared by reset directly, with no clearing pass.
// Depends on fbac_pkg, fbac_regfile and fbac_exec.
`default_nettype none

module four_bit_accumulator_cpu #(
  parameter int unsigned MemWords = fbac_pkg::MEM_WORDS
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_stall_o,
  input  wire fbac_pkg::fbac_in_t   in_word_i,
  output logic                      out_valid_o,
  input  wire logic                 out_stall_i,
  output fbac_pkg::fbac_out_t       out_word_o
);
  import fbac_pkg::*;

  logic      in_valid_q;
  fbac_in_t  in_word_q;
  logic      out_valid_q;
  fbac_out_t out_word_q;
  logic      advance;

  logic [ADDR_W-1:0] raddr_a, raddr_b;
  logic [BYTE_W-1:0] rdata_a, rdata_b;
  fbac_wr_t          wr;
  fbac_out_t         res;

  // execute when a word is held and the result slot is free or draining
  assign advance    = in_valid_q && !(out_valid_q && out_stall_i);
  assign in_stall_o = in_valid_q && !advance;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!in_stall_o && in_valid_i) begin
      in_word_q <= in_word_i;
    end
  end

  // memory
  fbac_regfile #(
    .MemWords (MemWords)
  ) u_regfile (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_i      (wr),
    .raddr_a_i (raddr_a),
    .raddr_b_i (raddr_b),
    .rdata_a_o (rdata_a),
    .rdata_b_o (rdata_b)
  );

  // execute unit
  fbac_exec u_exec (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .go_i      (advance),
    .word_i    (in_word_q),
    .raddr_a_o (raddr_a),
    .raddr_b_o (raddr_b),
    .rdata_a_i (rdata_a),
    .rdata_b_i (rdata_b),
    .wr_o      (wr),
    .res_o     (res)
  );

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_word_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

endmodule

`default_nettype wire
